// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on the rising clock, off during reset
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge
`define CHK_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== src/tcl_pkg.sv =====
`default_nettype none

package tcl_pkg;

    // Request and result payloads
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] sample_value;
        logic        frame_last;
        logic [31:0] trigger_value;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        read_valid;
        logic [1:0]  capture_state;
    } rsp_t;

    // Request modes
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_ARM    = 2'd1;
    localparam logic [1:0] MODE_STOP   = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    // Capture state codes as seen on the result
    localparam logic [1:0] CAP_ARMED   = 2'd0;
    localparam logic [1:0] CAP_HOLD    = 2'd1;
    localparam logic [1:0] CAP_STOPPED = 2'd2;

    // Trigger compare kinds
    localparam logic [1:0] CMP_EQ = 2'd0;
    localparam logic [1:0] CMP_GT = 2'd1;
    localparam logic [1:0] CMP_LT = 2'd2;

    // Register file
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_CHANNELS = 3'd0;
    localparam logic [2:0] REG_DECIM    = 3'd1;
    localparam logic [2:0] REG_COMPARE  = 3'd2;
    localparam logic [2:0] REG_POST     = 3'd3;
    localparam logic [2:0] REG_MASK     = 3'd4;
    localparam logic [2:0] REG_PATTERN  = 3'd5;

    localparam logic [15:0] DECIM_RESET   = 16'd9;
    localparam logic [31:0] PATTERN_RESET = 32'hffff_ffff;

    typedef struct packed {
        logic [4:0]  channel_count;
        logic [15:0] decimation_rate;
        logic [1:0]  compare_kind;
        logic [15:0] post_trigger_ticks;
        logic [31:0] trigger_mask;
        logic [31:0] trigger_pattern;
    } cfg_t;

endpackage

`default_nettype wire

// ===== src/tcl_regs.sv =====
`default_nettype none

module tcl_regs #(
    parameter int MAX_CHANNELS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [tcl_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output tcl_pkg::cfg_t                  cfg
);
    import tcl_pkg::*;

    localparam logic [4:0] CH_MAX = 5'(MAX_CHANNELS);

    cfg_t        cfg_reg;
    logic        wr;
    logic [2:0]  idx;
    logic [4:0]  ch_in;
    logic [4:0]  ch_fixed;

    assign wr    = psel && penable && pwrite;
    assign idx   = paddr[4:2];
    assign ch_in = pwdata[4:0];

    // Out-of-range channel counts fall back to one
    assign ch_fixed = (ch_in == 5'd0 || ch_in > CH_MAX) ? 5'd1 : ch_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count      <= CH_MAX;
            cfg_reg.decimation_rate    <= DECIM_RESET;
            cfg_reg.compare_kind       <= CMP_EQ;
            cfg_reg.post_trigger_ticks <= 16'd0;
            cfg_reg.trigger_mask       <= 32'd0;
            cfg_reg.trigger_pattern    <= PATTERN_RESET;
        end
        else if (wr)
        begin
            case (idx)
                REG_CHANNELS: cfg_reg.channel_count      <= ch_fixed;
                REG_DECIM:    cfg_reg.decimation_rate    <= pwdata[15:0];
                REG_COMPARE:  cfg_reg.compare_kind       <= pwdata[1:0];
                REG_POST:     cfg_reg.post_trigger_ticks <= pwdata[15:0];
                REG_MASK:     cfg_reg.trigger_mask       <= pwdata;
                REG_PATTERN:  cfg_reg.trigger_pattern    <= pwdata;
                default:      ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_CHANNELS: prdata = {27'd0, cfg_reg.channel_count};
            REG_DECIM:    prdata = {16'd0, cfg_reg.decimation_rate};
            REG_COMPARE:  prdata = {30'd0, cfg_reg.compare_kind};
            REG_POST:     prdata = {16'd0, cfg_reg.post_trigger_ticks};
            REG_MASK:     prdata = cfg_reg.trigger_mask;
            REG_PATTERN:  prdata = cfg_reg.trigger_pattern;
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/tcl_mem.sv =====
`default_nettype none

module tcl_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [31:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [31:0]        rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/tcl_ctrl.sv =====
`default_nettype none

module tcl_ctrl #(
    parameter int MEMORY_DEPTH = 4096,
    parameter int AW           = 12
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tcl_pkg::cfg_t cfg,
    input  wire logic          accept,
    input  wire tcl_pkg::req_t req,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    output logic [1:0]         state_next
);
    import tcl_pkg::*;

    typedef enum logic [1:0] {
        PH_ARMED   = CAP_ARMED,
        PH_HOLD    = CAP_HOLD,
        PH_STOPPED = CAP_STOPPED
    } phase_t;

    localparam logic [AW:0] DEPTH_W = (AW+1)'(MEMORY_DEPTH);

    // Depth mod (index + 1), worked out at elaboration
    localparam logic [3:0] DEPTH_MOD [16] = '{
        4'(MEMORY_DEPTH % 1),  4'(MEMORY_DEPTH % 2),  4'(MEMORY_DEPTH % 3),
        4'(MEMORY_DEPTH % 4),  4'(MEMORY_DEPTH % 5),  4'(MEMORY_DEPTH % 6),
        4'(MEMORY_DEPTH % 7),  4'(MEMORY_DEPTH % 8),  4'(MEMORY_DEPTH % 9),
        4'(MEMORY_DEPTH % 10), 4'(MEMORY_DEPTH % 11), 4'(MEMORY_DEPTH % 12),
        4'(MEMORY_DEPTH % 13), 4'(MEMORY_DEPTH % 14), 4'(MEMORY_DEPTH % 15),
        4'(MEMORY_DEPTH % 16)
    };

    function automatic logic [AW-1:0] wrap_addr(input logic [AW:0] a);
        logic [AW:0] b;
        b = a - DEPTH_W;
        return (a >= DEPTH_W) ? b[AW-1:0] : a[AW-1:0];
    endfunction

    phase_t        phase_reg,   phase_next;
    logic [AW-1:0] wr_idx_reg,  wr_idx_next;
    logic [AW-1:0] rd_idx_reg,  rd_idx_next;
    logic [15:0]   decim_reg,   decim_next;
    logic [15:0]   hold_reg,    hold_next;
    logic          stop_reg,    stop_next;
    logic [4:0]    word_reg,    word_next;

    logic          decim_due;
    logic          take;
    logic [AW-1:0] wr_idx_tick;
    logic [AW-1:0] base;
    logic [4:0]    ch_m1;
    logic [31:0]   masked;
    logic          hit;

    // Trigger compare
    always_comb
    begin
        masked = req.trigger_value & ~cfg.trigger_mask;
        case (cfg.compare_kind)
            CMP_EQ:  hit = (masked == cfg.trigger_pattern);
            CMP_GT:  hit = (masked > cfg.trigger_pattern);
            CMP_LT:  hit = (masked < cfg.trigger_pattern);
            default: hit = 1'b0;
        endcase
    end

    // Capture window and pointer arithmetic
    assign decim_due   = (decim_reg >= cfg.decimation_rate);
    assign take        = decim_due && (phase_reg == PH_ARMED || phase_reg == PH_HOLD);
    assign wr_addr     = wrap_addr({1'b0, wr_idx_reg} + (AW+1)'(word_reg));
    assign wr_idx_tick = take ? wrap_addr({1'b0, wr_idx_reg} + (AW+1)'(cfg.channel_count))
                              : wr_idx_reg;
    assign ch_m1       = cfg.channel_count - 5'd1;
    assign base        = wrap_addr({1'b0, wr_idx_tick} + (AW+1)'(DEPTH_MOD[ch_m1[3:0]]));
    assign rd_addr     = rd_idx_reg;

    // Next state for one request
    always_comb
    begin
        phase_next  = phase_reg;
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        decim_next  = decim_reg;
        hold_next   = hold_reg;
        stop_next   = stop_reg;
        word_next   = word_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        if (accept)
        begin
            case (req.mode)
                MODE_SAMPLE:
                begin
                    wr_en = take && (word_reg < cfg.channel_count);
                    if (req.frame_last)
                    begin
                        // End of frame: one tick
                        word_next   = 5'd0;
                        wr_idx_next = wr_idx_tick;
                        decim_next  = decim_due ? 16'd0 : decim_reg + 16'd1;
                        case (phase_reg)
                            PH_ARMED:
                            begin
                                if (hit || stop_reg)
                                begin
                                    stop_next  = 1'b0;
                                    hold_next  = cfg.post_trigger_ticks;
                                    phase_next = PH_HOLD;
                                end
                            end
                            PH_HOLD:
                            begin
                                if (hold_reg == 16'd0)
                                begin
                                    rd_idx_next = base;
                                    phase_next  = PH_STOPPED;
                                end
                                else
                                begin
                                    hold_next = hold_reg - 16'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    else if (word_reg != 5'd31)
                    begin
                        word_next = word_reg + 5'd1;
                    end
                end
                MODE_ARM:  phase_next = PH_ARMED;
                MODE_STOP: stop_next  = 1'b1;
                MODE_READ:
                begin
                    rd_en       = 1'b1;
                    rd_idx_next = wrap_addr({1'b0, rd_idx_reg} + (AW+1)'(1));
                end
                default: ;
            endcase
        end
    end

    assign state_next = phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ARMED;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            decim_reg  <= 16'd0;
            hold_reg   <= 16'd0;
            stop_reg   <= 1'b0;
            word_reg   <= 5'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            decim_reg  <= decim_next;
            hold_reg   <= hold_next;
            stop_reg   <= stop_next;
            word_reg   <= word_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/triggered_capture_logger.sv =====
// A result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle; a new request is taken while the result
// register drains, and req_stall rises only while a result waits under res_stall.
// Reset: control state and registers return to defaults at once; the capture
// memory is not cleared and needs no clearing pass.
`default_nettype none

module triggered_capture_logger #(
    parameter int MEMORY_DEPTH = 4096,
    parameter int MAX_CHANNELS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire tcl_pkg::req_t              req_data,
    output logic                            res_valid,
    input  wire logic                       res_stall,
    output tcl_pkg::rsp_t                   res_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tcl_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import tcl_pkg::*;

    localparam int AW = $clog2(MEMORY_DEPTH);

    cfg_t          cfg;
    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic [1:0]    state_next;

    logic          res_valid_reg, res_valid_next;
    logic          rd_valid_reg;
    logic [1:0]    state_reg;

    assign pready    = 1'b1;
    assign req_stall = res_valid_reg && res_stall;
    assign accept    = req_valid && !req_stall;

    tcl_regs #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    tcl_ctrl #(
        .MEMORY_DEPTH (MEMORY_DEPTH),
        .AW           (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .accept     (accept),
        .req        (req_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .state_next (state_next)
    );

    tcl_mem #(
        .DEPTH (MEMORY_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req_data.sample_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result register; read data itself sits in the memory's output register
    assign res_valid_next = accept || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            state_reg     <= CAP_ARMED;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                rd_valid_reg <= rd_en;
                state_reg    <= state_next;
            end
        end
    end

    assign res_valid              = res_valid_reg;
    assign res_data.read_data     = rd_valid_reg ? rd_data : 32'd0;
    assign res_data.read_valid    = rd_valid_reg;
    assign res_data.capture_state = state_reg;

endmodule

`default_nettype wire

// ===== src/tcl_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module tcl_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire tcl_pkg::req_t req_data,
    input wire logic          res_valid,
    input wire logic          res_stall,
    input wire tcl_pkg::rsp_t res_data
);
    import tcl_pkg::*;

    // Input is held back only by a waiting, stalled result
    `CHK_ASSERT(a_stall_cause, clk, rst_n,
        req_stall |-> (res_valid && res_stall),
        "req_stall without a stalled result")

    // A read request gives a read result on the next cycle
    `CHK_ASSERT(a_read_result, clk, rst_n,
        (req_valid && !req_stall && req_data.mode == MODE_READ) |=>
            (res_valid && res_data.read_valid),
        "read request lost its result")

    // Arm always shows the armed state on its result
    `CHK_ASSERT(a_arm_state, clk, rst_n,
        (req_valid && !req_stall && req_data.mode == MODE_ARM) |=>
            (res_valid && res_data.capture_state == CAP_ARMED),
        "arm did not return to armed")

    // Non-read results carry zero data
    `CHK_NEVER(a_zero_data, clk, rst_n,
        res_valid && !res_data.read_valid && res_data.read_data != 32'd0,
        "nonzero data on a non-read result")

    // A stalled result holds
    `CHK_ASSERT(a_res_hold, clk, rst_n,
        (res_valid && res_stall) |=> (res_valid && $stable(res_data)),
        "stalled result changed")

endmodule

bind triggered_capture_logger tcl_checker u_tcl_checker (.*);

`default_nettype wire
